// ===== rtl/core/rbd_pkg.sv =====
// Shared constants, codes and control types for the ring buffer deque.
package rbd_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int WIDTH_DEFAULT = 32;

  localparam int OP_W     = 3;
  localparam int STATUS_W = 2;

  localparam logic [OP_W-1:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [OP_W-1:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [OP_W-1:0] OP_POP_BACK   = 3'd2;
  localparam logic [OP_W-1:0] OP_POP_FRONT  = 3'd3;
  localparam logic [OP_W-1:0] OP_READ_INDEX = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR      = 3'd5;

  localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
  localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
  localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STATUS_W-1:0] ST_RANGE = 2'd3;

  // Per-cycle command broadcast to every cell of the row.
  typedef struct packed {
    logic push_front;   // shift row toward the back, new word into cell 0
    logic pop_front;    // shift row toward the front
    logic push_back;    // write the cell whose position equals the fill count
    logic load_carry;   // copy every element into its carry register
    logic shift_carry;  // move carries one cell toward the front
  } rbd_cell_ctrl_t;

endpackage

// ===== rtl/core/ring_buffer_deque.sv =====
// Top level of the ring buffer deque: a row of element cells and its sequencer.
//
//  channel   ports                                   handshake
//  --------  --------------------------------------  ------------------------------
//  command   operation, push_data, read_index        taken when start && !busy
//  result    result_data, status, fill_count         valid for one cycle with done
//
// Every transaction yields exactly one result. Push, pop front, clear, unused codes
// and every failed operation finish without a walk: done rises the cycle after start
// and busy stays low, so commands can issue back to back.
// Read at index k and pop back copy the row into the carry registers; the word
// walks one cell per cycle toward the front along the carry chain, and busy is
// high while it travels.
// Reset (rst, synchronous) empties the deque; stored words are not cleared since a
// cell beyond the fill count is never read. The receiver cannot stall: a result
// not taken in its done cycle is gone.
//
// Storage is a shift row: cell i always holds the element i positions from the
// front. Push/pop at the front shift the whole row by one cell; push at the back
// writes the cell at the fill count; index reads and pop back copy the row into
// the carry registers and shift them toward cell 0.
module ring_buffer_deque #(
  parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = rbd_pkg::WIDTH_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  output logic                          busy,
  input  logic [rbd_pkg::OP_W-1:0]      operation,
  input  logic [WIDTH-1:0]              push_data,
  input  logic [$clog2(DEPTH)-1:0]      read_index,
  output logic                          done,
  output logic [WIDTH-1:0]              result_data,
  output logic [rbd_pkg::STATUS_W-1:0]  status,
  output logic [$clog2(DEPTH+1)-1:0]    fill_count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  rbd_pkg::rbd_cell_ctrl_t cell_ctrl;
  logic [CW-1:0]           fill;

  // element and carry registers of each cell, read only at fixed neighbors
  logic [WIDTH-1:0] cell_data  [DEPTH];
  logic [WIDTH-1:0] cell_carry [DEPTH];

  rbd_ctrl #(
    .DEPTH (DEPTH),
    .WIDTH (WIDTH),
    .IW    (IW),
    .CW    (CW)
  ) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .operation   (operation),
    .read_index  (read_index),
    .front_data  (cell_data[0]),
    .front_carry (cell_carry[0]),
    .busy        (busy),
    .cell_ctrl   (cell_ctrl),
    .fill        (fill),
    .done        (done),
    .result_data (result_data),
    .status      (status)
  );

  assign fill_count = fill;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [WIDTH-1:0] front_nb;
    logic [WIDTH-1:0] back_nb;
    logic [WIDTH-1:0] back_cy;

    if (i == 0) begin : g_first
      assign front_nb = '0;
    end else begin : g_inner_f
      assign front_nb = cell_data[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign back_nb = '0;
      assign back_cy = '0;
    end else begin : g_inner_b
      assign back_nb = cell_data[i+1];
      assign back_cy = cell_carry[i+1];
    end

    rbd_cell #(
      .WIDTH (WIDTH),
      .CW    (CW),
      .INDEX (i)
    ) u_cell (
      .clk        (clk),
      .ctrl       (cell_ctrl),
      .fill       (fill),
      .push_data  (push_data),
      .front_data (front_nb),
      .back_data  (back_nb),
      .back_carry (back_cy),
      .data       (cell_data[i]),
      .carry      (cell_carry[i])
    );
  end

endmodule

// ===== rtl/core/rbd_cell.sv =====
// One storage cell of the deque row: an element register and a carry register.
module rbd_cell #(
  parameter int WIDTH = rbd_pkg::WIDTH_DEFAULT,
  parameter int CW    = 7,
  parameter int INDEX = 0
) (
  input  logic                   clk,
  input  rbd_pkg::rbd_cell_ctrl_t ctrl,
  input  logic [CW-1:0]          fill,
  input  logic [WIDTH-1:0]       push_data,
  input  logic [WIDTH-1:0]       front_data,   // element of the neighbor toward the front
  input  logic [WIDTH-1:0]       back_data,    // element of the neighbor toward the back
  input  logic [WIDTH-1:0]       back_carry,   // carry of the neighbor toward the back
  output logic [WIDTH-1:0]       data,
  output logic [WIDTH-1:0]       carry
);

  logic [WIDTH-1:0] data_next;
  logic [WIDTH-1:0] carry_next;

  always_comb begin
    data_next = data;
    priority if (ctrl.push_front) begin
      data_next = (INDEX == 0) ? push_data : front_data;
    end else if (ctrl.pop_front) begin
      data_next = back_data;
    end else if (ctrl.push_back && (fill == CW'(INDEX))) begin
      data_next = push_data;
    end else begin
      data_next = data;
    end
  end

  always_comb begin
    carry_next = carry;
    priority if (ctrl.load_carry) begin
      carry_next = data;
    end else if (ctrl.shift_carry) begin
      carry_next = back_carry;
    end else begin
      carry_next = carry;
    end
  end

  always_ff @(posedge clk) begin
    data  <= data_next;
    carry <= carry_next;
  end

endmodule

// ===== rtl/core/rbd_ctrl.sv =====
// Sequencer for the deque: fill count, operation decode, carry walk and result registers.
module rbd_ctrl #(
  parameter int DEPTH = rbd_pkg::DEPTH_DEFAULT,
  parameter int WIDTH = rbd_pkg::WIDTH_DEFAULT,
  parameter int IW    = $clog2(DEPTH),
  parameter int CW    = $clog2(DEPTH + 1)
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [rbd_pkg::OP_W-1:0]      operation,
  input  logic [IW-1:0]                 read_index,
  input  logic [WIDTH-1:0]              front_data,
  input  logic [WIDTH-1:0]              front_carry,
  output logic                          busy,
  output rbd_pkg::rbd_cell_ctrl_t       cell_ctrl,
  output logic [CW-1:0]                 fill,
  output logic                          done,
  output logic [WIDTH-1:0]              result_data,
  output logic [rbd_pkg::STATUS_W-1:0]  status
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic                         state;
  logic                         state_next;
  logic [CW-1:0]                fill_next;
  logic [IW-1:0]                steps;
  logic [IW-1:0]                steps_next;
  logic                         pop_walk;
  logic                         pop_walk_next;
  logic                         done_next;
  logic [WIDTH-1:0]             result_data_next;
  logic [rbd_pkg::STATUS_W-1:0] status_next;
  logic                         accept;
  logic                         is_full;
  logic                         is_empty;
  logic [CW-1:0]                fill_dec;

  assign busy     = (state == ST_WALK);
  assign accept   = start && !busy;
  assign is_full  = (fill == CW'(DEPTH));
  assign is_empty = (fill == '0);
  assign fill_dec = fill - CW'(1);

  always_comb begin
    state_next       = state;
    fill_next        = fill;
    steps_next       = steps;
    pop_walk_next    = pop_walk;
    done_next        = 1'b0;
    result_data_next = result_data;
    status_next      = status;
    cell_ctrl        = '0;

    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          result_data_next = '0;
          status_next      = rbd_pkg::ST_OK;
          done_next        = 1'b1;
          unique case (operation)
            rbd_pkg::OP_PUSH_BACK, rbd_pkg::OP_PUSH_FRONT: begin
              if (is_full) begin
                status_next = rbd_pkg::ST_FULL;
              end else begin
                cell_ctrl.push_back  = (operation == rbd_pkg::OP_PUSH_BACK);
                cell_ctrl.push_front = (operation == rbd_pkg::OP_PUSH_FRONT);
                fill_next            = fill + CW'(1);
              end
            end
            rbd_pkg::OP_POP_FRONT: begin
              if (is_empty) begin
                status_next = rbd_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.pop_front = 1'b1;
                result_data_next    = front_data;
                fill_next           = fill_dec;
              end
            end
            rbd_pkg::OP_POP_BACK: begin
              if (is_empty) begin
                status_next = rbd_pkg::ST_EMPTY;
              end else begin
                cell_ctrl.load_carry = 1'b1;
                steps_next           = fill_dec[IW-1:0];
                pop_walk_next        = 1'b1;
                done_next            = 1'b0;
                state_next           = ST_WALK;
              end
            end
            rbd_pkg::OP_READ_INDEX: begin
              if ({1'b0, read_index} >= (IW + 1)'(fill)) begin
                status_next = rbd_pkg::ST_RANGE;
              end else begin
                cell_ctrl.load_carry = 1'b1;
                steps_next           = read_index;
                pop_walk_next        = 1'b0;
                done_next            = 1'b0;
                state_next           = ST_WALK;
              end
            end
            rbd_pkg::OP_CLEAR: begin
              fill_next = '0;
            end
            default: begin
              // unused codes: no change, ok status
            end
          endcase
        end
      end
      ST_WALK: begin
        if (steps == '0) begin
          result_data_next = front_carry;
          status_next      = rbd_pkg::ST_OK;
          done_next        = 1'b1;
          state_next       = ST_IDLE;
          if (pop_walk) begin
            fill_next = fill_dec;
          end
        end else begin
          cell_ctrl.shift_carry = 1'b1;
          steps_next            = steps - IW'(1);
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      fill  <= '0;
      done  <= 1'b0;
    end else begin
      state <= state_next;
      fill  <= fill_next;
      done  <= done_next;
    end
  end

  always_ff @(posedge clk) begin
    steps       <= steps_next;
    pop_walk    <= pop_walk_next;
    result_data <= result_data_next;
    status      <= status_next;
  end

endmodule

// ===== tb/ring_buffer_deque_test.sv =====
// Self-checking testbench for the ring buffer deque: directed and random command traffic.
module ring_buffer_deque_test;

  localparam int DEPTH   = rbd_pkg::DEPTH_DEFAULT;
  localparam int WIDTH   = rbd_pkg::WIDTH_DEFAULT;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int COUNT_W = $clog2(DEPTH + 1);

  // Codes 6 and 7 have no operation behind them; the block must leave state alone.
  localparam logic [rbd_pkg::OP_W-1:0] OP_UNUSED_6 = 3'd6;
  localparam logic [rbd_pkg::OP_W-1:0] OP_UNUSED_7 = 3'd7;

  // Longest legal quiet stretch: a pop back over a full deque plus the longest
  // sender gap. The limit is many times that.
  localparam int STALL_LIMIT = 1000;

  typedef enum {MIX_FILL, MIX_DRAIN, MIX_EVEN} traffic_mix_t;

  typedef struct packed {
    logic [WIDTH-1:0]             data;
    logic [rbd_pkg::STATUS_W-1:0] status;
    logic [COUNT_W-1:0]           count;
  } deque_result_t;

  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          start = 1'b0;
  logic                          busy;
  logic [rbd_pkg::OP_W-1:0]      operation = '0;
  logic [WIDTH-1:0]              push_data = '0;
  logic [IDX_W-1:0]              read_index = '0;
  logic                          done;
  logic [WIDTH-1:0]              result_data;
  logic [rbd_pkg::STATUS_W-1:0]  status;
  logic [COUNT_W-1:0]            fill_count;

  ring_buffer_deque #(
    .DEPTH(DEPTH),
    .WIDTH(WIDTH)
  ) dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .operation(operation),
    .push_data(push_data),
    .read_index(read_index),
    .done(done),
    .result_data(result_data),
    .status(status),
    .fill_count(fill_count)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 0;
  end

  // ---------------------------------------------------------------------------
  // Deque predictor. Words sit in a circular array addressed by a head index
  // and an element count; the back is always (head + count - 1) mod DEPTH.
  // ---------------------------------------------------------------------------
  logic [WIDTH-1:0] deque_words [DEPTH];
  int               deque_head;
  int               deque_count;

  deque_result_t    pending_results [$];
  int               error_count;

  function automatic deque_result_t apply_deque_op(input logic [rbd_pkg::OP_W-1:0] op,
                                                   input logic [WIDTH-1:0] word,
                                                   input logic [IDX_W-1:0] idx);
    deque_result_t r;
    r = '0;
    r.status = rbd_pkg::ST_OK;
    case (op)
      rbd_pkg::OP_PUSH_BACK: begin
        if (deque_count >= DEPTH) begin
          r.status = rbd_pkg::ST_FULL;
        end else begin
          deque_words[(deque_head + deque_count) % DEPTH] = word;
          deque_count++;
        end
      end
      rbd_pkg::OP_PUSH_FRONT: begin
        if (deque_count >= DEPTH) begin
          r.status = rbd_pkg::ST_FULL;
        end else begin
          // first word into an empty deque always lands in slot 0
          if (deque_count == 0) deque_head = 0;
          else deque_head = (deque_head + DEPTH - 1) % DEPTH;
          deque_words[deque_head] = word;
          deque_count++;
        end
      end
      rbd_pkg::OP_POP_BACK: begin
        if (deque_count == 0) begin
          r.status = rbd_pkg::ST_EMPTY;
        end else begin
          r.data = deque_words[(deque_head + deque_count - 1) % DEPTH];
          deque_count--;
        end
      end
      rbd_pkg::OP_POP_FRONT: begin
        if (deque_count == 0) begin
          r.status = rbd_pkg::ST_EMPTY;
        end else begin
          r.data = deque_words[deque_head];
          deque_head = (deque_head + 1) % DEPTH;
          deque_count--;
        end
      end
      rbd_pkg::OP_READ_INDEX: begin
        if (int'(idx) >= deque_count) r.status = rbd_pkg::ST_RANGE;
        else r.data = deque_words[(deque_head + int'(idx)) % DEPTH];
      end
      rbd_pkg::OP_CLEAR: begin
        // stored words stay; only the pointers go back to reset
        deque_head = 0;
        deque_count = 0;
      end
      default: ;
    endcase
    r.count = COUNT_W'(deque_count);
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs change on the falling edge only. A transaction is taken
  // at the rising edge where start is high and busy is low; the expected result
  // is queued right there. The task returns at the next falling edge with start
  // still high, so back-to-back commands never drop start in between.
  // ---------------------------------------------------------------------------
  task automatic issue_cmd(input logic [rbd_pkg::OP_W-1:0] op,
                           input logic [WIDTH-1:0] word,
                           input logic [IDX_W-1:0] idx);
    start = 1'b1;
    operation = op;
    push_data = word;
    read_index = idx;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_results.push_back(apply_deque_op(op, word, idx));
    @(negedge clk);
  endtask

  task automatic hold_off(input int cycles);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Sender stops until every outstanding transaction has reported back.
  task automatic wait_all_results();
    start = 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Result checker and watchdog. Results cannot be held off, so every done
  // cycle is compared against the oldest expectation.
  // ---------------------------------------------------------------------------
  int quiet_cycles;

  always @(posedge clk) begin
    deque_result_t want;
    if (rst) begin
      quiet_cycles <= 0;
    end else begin
      if (done) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("unexpected result: data=%h status=%0d count=%0d",
                     result_data, status, fill_count);
        end else begin
          want = pending_results.pop_front();
          if (result_data !== want.data || status !== want.status ||
              fill_count !== want.count) begin
            error_count++;
            if (error_count <= 10)
              $display("mismatch: exp data=%h status=%0d count=%0d",
                       want.data, want.status, want.count,
                       ", got data=%h status=%0d count=%0d",
                       result_data, status, fill_count);
          end
        end
      end
      if (done || (start && !busy)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= STALL_LIMIT) begin
        $display("watchdog: no progress for %0d cycles", STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Every failing operation on an empty deque, plus the unused codes and a clear.
  task automatic test_empty_deque();
    issue_cmd(rbd_pkg::OP_POP_BACK, 32'hDEAD_BEEF, '0);
    issue_cmd(rbd_pkg::OP_POP_FRONT, 32'h1234_5678, '0);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '0, '0);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '1, '1);
    issue_cmd(OP_UNUSED_6, '1, '1);
    issue_cmd(OP_UNUSED_7, 32'h8000_0001, 6'h2A);
    issue_cmd(rbd_pkg::OP_CLEAR, '1, '1);
  endtask

  // Front push into an empty deque, data extremes, reads at and past the end,
  // then clear and reuse.
  task automatic test_both_ends();
    issue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'hA5A5_5A5A, '0);
    issue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'h0F0F_F0F0, '0);
    issue_cmd(rbd_pkg::OP_PUSH_BACK, '1, '0);
    issue_cmd(rbd_pkg::OP_PUSH_BACK, '0, '1);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '0, 6'd0);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '0, 6'd3);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '0, 6'd4);
    issue_cmd(rbd_pkg::OP_POP_BACK, '0, '0);
    issue_cmd(rbd_pkg::OP_POP_FRONT, '0, '0);
    issue_cmd(OP_UNUSED_6, '0, '0);
    issue_cmd(rbd_pkg::OP_CLEAR, '0, '0);
    issue_cmd(rbd_pkg::OP_READ_INDEX, '0, 6'd0);
    issue_cmd(rbd_pkg::OP_PUSH_FRONT, 32'h0000_0001, '0);
    issue_cmd(rbd_pkg::OP_POP_BACK, '0, '0);
  endtask

  function automatic logic [rbd_pkg::OP_W-1:0] pick_op(input traffic_mix_t mix);
    int r;
    r = $urandom_range(0, 99);
    case (mix)
      MIX_FILL: begin
        if (r < 40) return rbd_pkg::OP_PUSH_BACK;
        if (r < 75) return rbd_pkg::OP_PUSH_FRONT;
        if (r < 82) return rbd_pkg::OP_POP_BACK;
        if (r < 88) return rbd_pkg::OP_POP_FRONT;
        if (r < 97) return rbd_pkg::OP_READ_INDEX;
        if (r < 98) return rbd_pkg::OP_CLEAR;
      end
      MIX_DRAIN: begin
        if (r < 10) return rbd_pkg::OP_PUSH_BACK;
        if (r < 20) return rbd_pkg::OP_PUSH_FRONT;
        if (r < 50) return rbd_pkg::OP_POP_BACK;
        if (r < 80) return rbd_pkg::OP_POP_FRONT;
        if (r < 96) return rbd_pkg::OP_READ_INDEX;
        if (r < 97) return rbd_pkg::OP_CLEAR;
      end
      default: begin
        if (r < 22) return rbd_pkg::OP_PUSH_BACK;
        if (r < 44) return rbd_pkg::OP_PUSH_FRONT;
        if (r < 60) return rbd_pkg::OP_POP_BACK;
        if (r < 76) return rbd_pkg::OP_POP_FRONT;
        if (r < 95) return rbd_pkg::OP_READ_INDEX;
        if (r < 97) return rbd_pkg::OP_CLEAR;
      end
    endcase
    return ($urandom_range(0, 1) != 0) ? OP_UNUSED_7 : OP_UNUSED_6;
  endfunction

  // Random commands. Index reads mostly aim at or just past the filled range;
  // the rest span the whole index field. Sender gaps come in bursts when enabled.
  task automatic test_random_traffic(input traffic_mix_t mix, input int items,
                                     input bit gaps);
    logic [rbd_pkg::OP_W-1:0] op;
    logic [WIDTH-1:0]         word;
    logic [IDX_W-1:0]         idx;
    for (int n = 0; n < items; n++) begin
      op = pick_op(mix);
      word = $urandom;
      if ($urandom_range(0, 15) == 0) word = ($urandom_range(0, 1) != 0) ? '1 : '0;
      if ($urandom_range(0, 3) != 0) idx = IDX_W'($urandom_range(0, deque_count));
      else idx = IDX_W'($urandom_range(0, DEPTH - 1));
      issue_cmd(op, word, idx);
      if (gaps && $urandom_range(0, 5) == 0) hold_off($urandom_range(1, 15));
    end
  endtask

  initial begin
    error_count = 0;
    deque_head = 0;
    deque_count = 0;
    for (int i = 0; i < DEPTH; i++) deque_words[i] = '0;

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_empty_deque();
    test_both_ends();
    wait_all_results();

    // Alternate fill, drain and even phases so the deque swings between empty
    // and full; a few phases run with no sender gaps at all.
    for (int p = 0; p < 17; p++) begin
      test_random_traffic(traffic_mix_t'(p % 3), 100, (p % 4) != 3);
      if (p % 5 == 4) wait_all_results();
    end
    // Closing stretch: commands back to back, no gaps.
    test_random_traffic(MIX_FILL, 100, 1'b0);
    test_random_traffic(MIX_EVEN, 100, 1'b0);
    test_random_traffic(MIX_DRAIN, 100, 1'b0);

    wait_all_results();
    hold_off(DEPTH + 8);

    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
